// ===== rtl/lotfs_pkg.sv =====
// Package for the linear offset to file slice mapper.
// Holds the beat structs, request and status codes and table constants.
// No dependencies.
package lotfs_pkg;

  localparam int unsigned DefMaxFiles  = 1024;
  localparam int unsigned DefMaxSlices = 64;
  localparam logic [24:0] PlReset      = 25'd262144;
  localparam logic [24:0] PlMax        = 25'd16777216;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_BLOCK  = 2'd1,
    REQ_FILE   = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [30:0] piece;
    logic [23:0] piece_offset;
    logic [9:0]  file_sel;
    logic [47:0] file_pos;
    logic [24:0] request_size;
    logic [47:0] file_size;
    logic [47:0] base_ofs;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slice_file;
    logic [47:0] slice_offset;
    logic [24:0] slice_size;
    logic [30:0] piece_index;
    logic [23:0] piece_start;
    logic [24:0] piece_length_out;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [47:0] start;
    logic [47:0] size;
    logic [47:0] base;
  } entry_t;

endpackage

// ===== rtl/lotfs_table.sv =====
// File table memory: start, size and base of every appended file.
// One write port and one read port with registered read data.
// Depends on lotfs_pkg.
module lotfs_table import lotfs_pkg::*; #(
  parameter int unsigned MaxFiles = DefMaxFiles,
  localparam int unsigned Iw = (MaxFiles > 1) ? $clog2(MaxFiles) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Iw-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [Iw-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [MaxFiles];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lotfs_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Divides a 49-bit linear offset by the 25-bit piece length. Depends on lotfs_pkg.
module lotfs_divider import lotfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [48:0] dividend_i,
  input  logic [24:0] divisor_i,
  output logic        done_o,
  output logic [48:0] quot_o,
  output logic [24:0] rem_o
);

  logic [48:0] quot_q, quot_d;
  logic [24:0] rem_q, rem_d;
  logic [24:0] div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [25:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[48]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 6'd49;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = 25'(trial - {1'b0, div_q});
        quot_d = {quot_q[47:0], 1'b1};
      end else begin
        rem_d = trial[24:0];
        quot_d = {quot_q[47:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/linear_offset_to_file_slices.sv =====
// An append is done in S_DISPATCH. A block request passes S_DISPATCH, S_POS, S_CHK, the
// binary search over the file table in S_BS and S_BSC (at most log2 of the file count,
// rounded down, plus one steps), S_FO and S_WALK, which reads each file touched from the
// single table port; a slice beat leaves in every walk step that covers bytes. A file
// request reads its entry in S_FRD, then waits in S_DIV on the one-bit-per-cycle divider.
// Results cannot be stalled: each beat is shown for one cycle with res_valid_o; busy is
// low when the last one shows. Depends on lotfs_pkg, lotfs_table and lotfs_divider.
module linear_offset_to_file_slices import lotfs_pkg::*; #(
  parameter int unsigned MaxFiles  = DefMaxFiles,
  parameter int unsigned MaxSlices = DefMaxSlices
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic [24:0] cfg_data_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  localparam int unsigned Iw = (MaxFiles > 1) ? $clog2(MaxFiles) : 1;
  localparam int unsigned Cw = $clog2(MaxFiles + 1);
  localparam int unsigned Sw = $clog2(MaxSlices + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_POS, S_CHK, S_BS, S_BSC, S_FO, S_WALK, S_FRD, S_DIV
  } state_e;

  state_e      state_q, state_d;
  req_t        req_q, req_d;
  logic [24:0] pl_q, pl_d, pl_eff;
  logic [47:0] total_q, total_d;
  logic [Cw-1:0] cnt_q, cnt_d, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, idx_q, idx_d;
  logic [Sw-1:0] n_q, n_d;
  logic [56:0] pos_q, pos_d;
  logic [47:0] fo_q, fo_d;
  logic [24:0] rem_q, rem_d;
  logic        res_valid_q, res_valid_d;
  res_t        res_q, res_d;

  logic        we, re;
  logic [Iw-1:0] raddr;
  entry_t      wdata, rd;
  logic        div_start, div_done;
  logic [48:0] div_quot;
  logic [24:0] div_rem;
  logic [48:0] lin_q, lin_d;
  logic        div_go_q;

  logic [48:0] app_sum;
  logic [57:0] end_pos;
  logic [Cw-1:0] mid_c;
  logic [47:0] take, avail;

  lotfs_table #(.MaxFiles(MaxFiles)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[Iw-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  lotfs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lin_q),
    .divisor_i  (pl_eff),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    if (pl_q == '0) begin
      pl_eff = 25'd1;
    end else if (pl_q > PlMax) begin
      pl_eff = PlMax;
    end else begin
      pl_eff = pl_q;
    end
  end

  assign wdata   = '{start: total_q, size: req_q.file_size, base: req_q.base_ofs};
  assign app_sum = {1'b0, total_q} + {1'b0, req_q.file_size};
  assign end_pos = {1'b0, pos_q} + 58'(req_q.request_size);
  assign mid_c   = lo_q + ((hi_q - lo_q) >> 1);
  assign avail   = rd.size - fo_q;
  assign take    = (avail > 48'(rem_q)) ? 48'(rem_q) : avail;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    pl_d        = cfg_we_i ? cfg_data_i : pl_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    n_d         = n_q;
    pos_d       = pos_q;
    fo_d        = fo_q;
    rem_d       = rem_q;
    lin_d       = lin_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = idx_q[Iw-1:0];
    div_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_d.last = 1'b1;
        res_d.status = ST_RANGE;
        state_d = S_IDLE;
        case (req_q.req_type)
          REQ_APPEND: begin
            if (cnt_q >= Cw'(MaxFiles)) begin
              res_valid_d  = 1'b1;
              res_d.status = ST_FULL;
            end else if (app_sum[48]) begin
              res_valid_d = 1'b1;
            end else begin
              we               = 1'b1;
              total_d          = app_sum[47:0];
              cnt_d            = cnt_q + Cw'(1);
              res_valid_d      = 1'b1;
              res_d.status     = ST_OK;
              res_d.slice_file = 10'(cnt_q);
            end
          end
          REQ_BLOCK: begin
            pos_d   = 57'(req_q.piece) * {32'd0, pl_eff};
            state_d = S_POS;
          end
          REQ_FILE: begin
            if (32'(req_q.file_sel) >= 32'(cnt_q)) begin
              res_valid_d = 1'b1;
            end else begin
              re      = 1'b1;
              raddr   = Iw'(req_q.file_sel);
              state_d = S_FRD;
            end
          end
          default: begin
            res_valid_d = 1'b1;
          end
        endcase
      end
      S_POS: begin
        pos_d   = pos_q + 57'(req_q.piece_offset);
        state_d = S_CHK;
      end
      S_CHK: begin
        if (cnt_q == '0 || req_q.request_size == '0 || end_pos > 58'(total_q)) begin
          res_valid_d  = 1'b1;
          res_d.status = ST_RANGE;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          lo_d    = '0;
          hi_d    = cnt_q;
          n_d     = '0;
          rem_d   = req_q.request_size;
          state_d = S_BS;
        end
      end
      S_BS: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_c;
          re      = 1'b1;
          raddr   = mid_c[Iw-1:0];
          state_d = S_BSC;
        end else begin
          idx_d   = (lo_q == '0) ? '0 : lo_q - Cw'(1);
          re      = 1'b1;
          raddr   = idx_d[Iw-1:0];
          state_d = S_FO;
        end
      end
      S_BSC: begin
        if (57'(rd.start) <= pos_q) begin
          lo_d = mid_q + Cw'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = S_BS;
      end
      S_FO: begin
        fo_d    = pos_q[47:0] - rd.start;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (fo_q < rd.size) begin
          res_valid_d        = 1'b1;
          res_d.slice_file   = 10'(idx_q);
          res_d.slice_offset = fo_q + rd.base;
          res_d.slice_size   = take[24:0];
          rem_d              = rem_q - take[24:0];
          fo_d               = '0;
          n_d                = n_q + Sw'(1);
          if (rem_q == take[24:0]) begin
            res_d.last = 1'b1;
            state_d    = S_IDLE;
          end else if (32'(n_q) + 32'd1 >= 32'(MaxSlices)) begin
            res_d.last   = 1'b1;
            res_d.status = ST_TRUNCATED;
            state_d      = S_IDLE;
          end
        end else begin
          fo_d = fo_q - rd.size;
        end
        if (state_d == S_WALK) begin
          if (idx_q + Cw'(1) >= cnt_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + Cw'(1);
            re    = 1'b1;
            raddr = idx_d[Iw-1:0];
          end
        end
      end
      S_FRD: begin
        lin_d   = {1'b0, req_q.file_pos} + {1'b0, rd.start};
        state_d = S_DIV;
      end
      S_DIV: begin
        div_start = div_go_q;
        if (div_done) begin
          res_valid_d = 1'b1;
          res_d.last  = 1'b1;
          if (div_quot[48:31] != '0) begin
            res_d.status = ST_RANGE;
          end else begin
            res_d.piece_index      = div_quot[30:0];
            res_d.piece_start      = div_rem[23:0];
            res_d.piece_length_out = req_q.request_size;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pl_q        <= PlReset;
      total_q     <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      div_go_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      pl_q        <= pl_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      div_go_q    <= (state_q == S_FRD);
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    idx_q <= idx_d;
    n_q   <= n_d;
    pos_q <= pos_d;
    fo_q  <= fo_d;
    rem_q <= rem_d;
    lin_q <= lin_d;
    res_q <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Cw'(MaxFiles))
    else $error("File count exceeds table depth.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("Result beat follows the last beat of a request.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_TRUNCATED |-> res_o.last)
    else $error("Truncated beat is not marked last.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("Block went idle before its last beat.");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for linear_offset_to_file_slices: directed table, then random beats.
// An internal file-table predictor computes the expected result beats, except for directed rows that give their own.
// Depends on lotfs_pkg and the linear_offset_to_file_slices RTL.
`timescale 1ns / 100ps

module tb;
  import lotfs_pkg::*;

  localparam logic [1:0]  ReqUnknown = 2'd3;
  localparam logic [47:0] Max48      = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned NumFiles   = DefMaxFiles;

  typedef struct {
    req_t req;
    bit   typed;
    res_t res;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        cfg_we_i;
  logic [24:0] cfg_data_i;
  logic        res_valid_o;
  res_t        res_o;

  logic [47:0] tbl_start [NumFiles];
  logic [47:0] tbl_size  [NumFiles];
  logic [47:0] tbl_base  [NumFiles];
  logic [47:0] total_len;
  int unsigned file_cnt;
  logic [24:0] piece_len;
  res_t        slice_q[$];
  row_t        rows[$];
  int          err_cnt;

  linear_offset_to_file_slices u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic void expect_beat(input res_t b);
    slice_q.insert(slice_q.size(), b);
  endfunction

  function automatic void add_row(input row_t w);
    rows.insert(rows.size(), w);
  endfunction

  function automatic res_t mk_res(logic [1:0] st, logic [9:0] f, logic [47:0] off,
                                  logic [24:0] sz, logic [30:0] pi, logic [23:0] ps,
                                  logic [24:0] plo, logic lst);
    res_t r;
    r.status = st;
    r.slice_file = f;
    r.slice_offset = off;
    r.slice_size = sz;
    r.piece_index = pi;
    r.piece_start = ps;
    r.piece_length_out = plo;
    r.last = lst;
    return r;
  endfunction

  function automatic res_t range_res();
    return mk_res(ST_RANGE, '0, '0, '0, '0, '0, '0, 1'b1);
  endfunction

  function automatic logic [63:0] eff_piece_len();
    if (piece_len == 0) return 64'd1;
    if (piece_len > PlMax) return 64'(PlMax);
    return 64'(piece_len);
  endfunction

  // Models the mapper on the file table for each request type and queues the beats it must produce.
  task automatic map_request(input req_t r);
    logic [63:0] pl, pos, rem, fo, take, sz, lin, q;
    int unsigned lo, hi, mid, idx;
    int          n;
    pl = eff_piece_len();
    case (r.req_type)
      REQ_APPEND: begin
        if (file_cnt >= NumFiles) begin
          expect_beat(mk_res(ST_FULL, '0, '0, '0, '0, '0, '0, 1'b1));
        end else if (64'(total_len) + 64'(r.file_size) > 64'(Max48)) begin
          expect_beat(range_res());
        end else begin
          tbl_start[file_cnt] = total_len;
          tbl_size[file_cnt] = r.file_size;
          tbl_base[file_cnt] = r.base_ofs;
          total_len = total_len + r.file_size;
          expect_beat(mk_res(ST_OK, 10'(file_cnt), '0, '0, '0, '0, '0, 1'b1));
          file_cnt++;
        end
      end
      REQ_BLOCK: begin
        pos = 64'(r.piece) * pl + 64'(r.piece_offset);
        rem = 64'(r.request_size);
        if (file_cnt == 0 || rem == 0 || pos + rem > 64'(total_len)) begin
          expect_beat(range_res());
        end else begin
          lo = 0;
          hi = file_cnt;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (64'(tbl_start[mid]) <= pos) lo = mid + 1;
            else hi = mid;
          end
          idx = (lo == 0) ? 0 : lo - 1;
          fo = pos - 64'(tbl_start[idx]);
          n = 0;
          while (rem > 0 && idx < file_cnt) begin
            sz = 64'(tbl_size[idx]);
            if (fo < sz) begin
              take = sz - fo;
              if (take > rem) take = rem;
              rem -= take;
              if (rem == 0) begin
                expect_beat(mk_res(ST_OK, 10'(idx), 48'(fo + 64'(tbl_base[idx])),
                                   25'(take), '0, '0, '0, 1'b1));
                return;
              end
              if (n + 1 >= DefMaxSlices) begin
                expect_beat(mk_res(ST_TRUNCATED, 10'(idx),
                                   48'(fo + 64'(tbl_base[idx])), 25'(take),
                                   '0, '0, '0, 1'b1));
                return;
              end
              expect_beat(mk_res(ST_OK, 10'(idx), 48'(fo + 64'(tbl_base[idx])),
                                 25'(take), '0, '0, '0, 1'b0));
              n++;
              fo += take;
            end
            fo = (fo >= sz) ? fo - sz : 0;
            idx++;
          end
        end
      end
      REQ_FILE: begin
        if (32'(r.file_sel) >= file_cnt) begin
          expect_beat(range_res());
        end else begin
          lin = 64'(r.file_pos) + 64'(tbl_start[r.file_sel]);
          q = lin / pl;
          if (q > 64'h7FFF_FFFF) expect_beat(range_res());
          else expect_beat(mk_res(ST_OK, '0, '0, '0, 31'(q), 24'(lin % pl),
                                  r.request_size, 1'b1));
        end
      end
      default: expect_beat(range_res());
    endcase
  endtask

  task automatic send(input req_t r, input bit typed, input res_t t);
    int unsigned gap;
    int          keep;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_i = r;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    if (typed) begin
      keep = slice_q.size();
      map_request(r);
      while (slice_q.size() > keep) void'(slice_q.pop_back());
      expect_beat(t);
    end else begin
      map_request(r);
    end
    @(negedge clk_i);
  endtask

  task automatic set_piece_len(input logic [24:0] v);
    start = 1'b0;
    while (slice_q.size() != 0 || busy) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_data_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    piece_len = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t rand_noise();
    req_t         r;
    logic [255:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = req_t'(raw[$bits(req_t)-1:0]);
    if (r.req_type == REQ_APPEND) r.req_type = ReqUnknown;
    return r;
  endfunction

  // Mostly well-formed requests against the current table, with some noise mixed in.
  function automatic req_t rand_req(input logic [47:0] max_file);
    req_t        r;
    int unsigned sel;
    logic [63:0] pl, pos, span, cap;
    r = rand_noise();
    pl = eff_piece_len();
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      r.req_type = REQ_APPEND;
      r.file_size = ($urandom_range(0, 7) == 0) ? '0 : 48'(rand64() % (64'(max_file) + 1));
      r.base_ofs = 48'(rand64());
    end else if (sel < 65 && total_len != 0) begin
      r.req_type = REQ_BLOCK;
      pos = rand64() % 64'(total_len);
      span = 64'(total_len) - pos;
      cap = $urandom_range(0, 1) ? 64'd300 : 64'd16777216;
      if (cap > span) cap = span;
      r.request_size = 25'(1 + rand64() % cap);
      r.piece = 31'(pos / pl);
      r.piece_offset = 24'(pos % pl);
    end else if (sel < 85 && file_cnt != 0) begin
      r.req_type = REQ_FILE;
      r.file_sel = 10'($urandom_range(0, file_cnt - 1));
      if ($urandom_range(0, 3) != 0)
        r.file_pos = 48'(rand64() % (64'(tbl_size[r.file_sel]) + pl + 1));
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && res_valid_o) begin
      if (slice_q.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        e = slice_q.pop_front();
        check_field("status", 64'(e.status), 64'(res_o.status));
        check_field("slice_file", 64'(e.slice_file), 64'(res_o.slice_file));
        check_field("slice_offset", 64'(e.slice_offset), 64'(res_o.slice_offset));
        check_field("slice_size", 64'(e.slice_size), 64'(res_o.slice_size));
        check_field("piece_index", 64'(e.piece_index), 64'(res_o.piece_index));
        check_field("piece_start", 64'(e.piece_start), 64'(res_o.piece_start));
        check_field("piece_length_out", 64'(e.piece_length_out),
                    64'(res_o.piece_length_out));
        check_field("last", 64'(e.last), 64'(res_o.last));
      end
    end
  end

  function automatic row_t mk_row(input logic [1:0] typ, input logic [30:0] pc,
                                  input logic [23:0] po, input logic [9:0] fi,
                                  input logic [47:0] fo, input logic [24:0] rs,
                                  input logic [47:0] fs, input logic [47:0] fb,
                                  input bit typed, input res_t t);
    row_t w;
    w.req = '{typ, pc, po, fi, fo, rs, fs, fb};
    w.typed = typed;
    w.res = t;
    return w;
  endfunction

  initial begin
    res_t none;
    req_t app;
    none = '0;
    err_cnt = 0;
    total_len = '0;
    file_cnt = 0;
    piece_len = PlReset;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    add_row(mk_row(REQ_BLOCK, 0, 0, 0, 0, 1, 0, 0, 1, range_res()));
    add_row(mk_row(REQ_FILE, 0, 0, 0, 0, 5, 0, 0, 1, range_res()));
    add_row(mk_row(ReqUnknown, '1, '1, '1, '1, '1, '1, '1, 1, range_res()));
    add_row(mk_row(REQ_APPEND, 0, 0, 0, 0, 0, 0, Max48, 1,
                   mk_res(ST_OK, '0, '0, '0, '0, '0, '0, 1'b1)));
    add_row(mk_row(REQ_APPEND, 0, 0, 0, 0, 0, 100, 0, 0, none));
    add_row(mk_row(REQ_APPEND, 0, 0, 0, 0, 0, 1, 5, 0, none));
    add_row(mk_row(REQ_APPEND, 0, 0, 0, 0, 0, 0, 7, 0, none));
    add_row(mk_row(REQ_APPEND, 0, 0, 0, 0, 0, 300, 1000, 0, none));
    add_row(mk_row(REQ_APPEND, 0, 0, 0, 0, 0, Max48, 0, 1, range_res()));
    add_row(mk_row(REQ_BLOCK, 0, 0, 0, 0, 0, 0, 0, 1, range_res()));
    add_row(mk_row(REQ_BLOCK, 0, 400, 0, 0, 2, 0, 0, 1, range_res()));
    add_row(mk_row(REQ_BLOCK, 0, 0, 0, 0, 401, 0, 0, 0, none));
    add_row(mk_row(REQ_BLOCK, 0, 99, 0, 0, 2, 0, 0, 0, none));
    add_row(mk_row(REQ_BLOCK, 0, 400, 0, 0, 1, 0, 0, 0, none));
    add_row(mk_row(REQ_BLOCK, 0, 0, 0, 0, 25'd16777216, 0, 0, 1, range_res()));
    add_row(mk_row(REQ_BLOCK, '1, '1, 0, 0, 25'd16777216, 0, 0, 1, range_res()));
    add_row(mk_row(REQ_FILE, 0, 0, 4, 5, 25'd16777216, 0, 0, 0, none));
    add_row(mk_row(REQ_FILE, 0, 0, 5, 0, 1, 0, 0, 1, range_res()));
    add_row(mk_row(REQ_FILE, 0, 0, 1, Max48, 0, 0, 0, 0, none));
    add_row(mk_row(REQ_FILE, 0, 0, '1, 0, 0, 0, 0, 1, range_res()));
    foreach (rows[k]) send(rows[k].req, rows[k].typed, rows[k].res);

    set_piece_len(25'd1);
    repeat (120) send(rand_req(48'd3), 0, none);
    set_piece_len(25'd0);
    repeat (80) send(rand_req(48'd40), 0, none);
    set_piece_len(25'h1FF_FFFF);
    repeat (80) send(rand_req(48'd67108864), 0, none);
    set_piece_len(25'($urandom_range(1, 25'h1FF_FFFF)));
    repeat (100) send(rand_req(48'd5000), 0, none);
    set_piece_len(25'd16777216);
    app = '0;
    app.req_type = REQ_APPEND;
    app.file_size = 48'd1;
    repeat (3) send(app, 0, none);
    set_piece_len(25'($urandom_range(1, 4096)));
    repeat (60) send(rand_req(48'd2), 0, none);

    start = 1'b0;
    while (slice_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lotfs_pkg.sv
rtl/lotfs_table.sv
rtl/lotfs_divider.sv
rtl/linear_offset_to_file_slices.sv
test/tb.sv
